>>> design/tspq_pkg.sv
package tspq_pkg;

    localparam int VALUE_BITS = 16;
    localparam int ENTRIES    = 64;
    localparam int COUNT_MAX  = 2;

    localparam int ADD_W   = 16;
    localparam int QUERY_W = 17;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W  = $clog2(ENTRIES + 1);
    localparam int CNT_W   = $clog2(COUNT_MAX + 1);
    localparam int SUM_W   = (VALUE_BITS + 1 > QUERY_W) ? VALUE_BITS + 1 : QUERY_W;

    typedef enum logic
    {
        OPC_ADD  = 1'b0,
        OPC_FIND = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic load;
        logic adv_j;
        logic adv_i;
        logic inc;
        logic append;
        logic set_found;
        logic publish;
    } tspq_cmd_t;

    typedef struct packed
    {
        logic op_find;
        logic used_zero;
        logic match;
        logic pair_hit;
        logic j_last;
        logic i_last;
        logic out_free;
    } tspq_status_t;

endpackage

>>> design/tspq_ctrl.sv
module tspq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tspq_pkg::tspq_status_t status,
    output tspq_pkg::tspq_cmd_t    cmd
);
    import tspq_pkg::*;

    typedef enum logic [5:0]
    {
        S_IDLE     = 6'b000001,
        S_ADD_RD   = 6'b000010,
        S_ADD_CHK  = 6'b000100,
        S_FIND_RD  = 6'b001000,
        S_FIND_CHK = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.op_find ? S_FIND_RD : S_ADD_RD;
                end
            end
            S_ADD_RD:
            begin
                if (status.used_zero)
                begin
                    cmd.append = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ADD_CHK;
                end
            end
            S_ADD_CHK:
            begin
                if (status.match)
                begin
                    cmd.inc    = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.j_last)
                begin
                    cmd.append = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.adv_j  = 1'b1;
                    state_next = S_ADD_RD;
                end
            end
            S_FIND_RD:
            begin
                state_next = status.used_zero ? S_DONE : S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (status.pair_hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (status.j_last && status.i_last)
                begin
                    state_next = S_DONE;
                end
                else if (status.j_last)
                begin
                    cmd.adv_i  = 1'b1;
                    state_next = S_FIND_RD;
                end
                else
                begin
                    cmd.adv_j  = 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/tspq_datapath.sv
module tspq_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 opcode,
    input  logic signed [tspq_pkg::ADD_W-1:0]    add_value,
    input  logic signed [tspq_pkg::QUERY_W-1:0]  query_sum,
    input  tspq_pkg::tspq_cmd_t                  cmd,
    output tspq_pkg::tspq_status_t               status,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic                                 pair_found,
    output logic                                 add_dropped
);
    import tspq_pkg::*;

    logic signed [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [CNT_W-1:0]             count_mem [ENTRIES];

    logic signed [VALUE_BITS-1:0] val_reg;
    logic signed [QUERY_W-1:0]    query_reg;
    logic [IDX_W-1:0]             i_reg;
    logic [IDX_W-1:0]             j_reg;
    logic [USED_W-1:0]            used_reg;
    logic signed [VALUE_BITS-1:0] rd_a_reg;
    logic signed [VALUE_BITS-1:0] rd_b_reg;
    logic [CNT_W-1:0]             cnt_b_reg;
    logic                         found_reg;
    logic                         dropped_reg;
    logic                         rsp_valid_reg;
    logic                         pair_found_reg;
    logic                         add_dropped_reg;

    logic                         full;
    logic [IDX_W-1:0]             i_inc;
    logic signed [SUM_W-1:0]      pair_sum;
    logic [CNT_W-1:0]             cnt_inc;

    assign full     = (used_reg == USED_W'(ENTRIES));
    assign i_inc    = i_reg + IDX_W'(1);
    assign pair_sum = SUM_W'(rd_a_reg) + SUM_W'(rd_b_reg);
    assign cnt_inc  = (cnt_b_reg == CNT_W'(COUNT_MAX)) ? cnt_b_reg : cnt_b_reg + CNT_W'(1);

    assign status.op_find   = (opcode == OPC_FIND);
    assign status.used_zero = (used_reg == '0);
    assign status.match     = (rd_b_reg == val_reg);
    assign status.pair_hit  = (pair_sum == SUM_W'(query_reg))
                              && ((i_reg != j_reg) || (cnt_b_reg == CNT_W'(COUNT_MAX)));
    assign status.j_last    = ((USED_W'(j_reg) + USED_W'(1)) == used_reg);
    assign status.i_last    = ((USED_W'(i_reg) + USED_W'(1)) == used_reg);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid   = rsp_valid_reg;
    assign pair_found  = pair_found_reg;
    assign add_dropped = add_dropped_reg;

    // table storage
    always_ff @(posedge clk)
    begin
        rd_a_reg  <= value_mem[i_reg];
        rd_b_reg  <= value_mem[j_reg];
        cnt_b_reg <= count_mem[j_reg];
        if (cmd.append && !full)
        begin
            value_mem[used_reg[IDX_W-1:0]] <= val_reg;
            count_mem[used_reg[IDX_W-1:0]] <= CNT_W'(1);
        end
        else if (cmd.inc)
        begin
            count_mem[j_reg] <= cnt_inc;
        end
    end

    // transaction payload and scan indices
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg   <= VALUE_BITS'(add_value);
            query_reg <= query_sum;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else if (cmd.adv_i)
        begin
            i_reg <= i_inc;
            j_reg <= i_inc;
        end
        else if (cmd.adv_j)
        begin
            j_reg <= j_reg + IDX_W'(1);
        end
        if (cmd.publish)
        begin
            pair_found_reg  <= found_reg;
            add_dropped_reg <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            found_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                found_reg   <= 1'b0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            else if (cmd.append)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    used_reg <= used_reg + USED_W'(1);
                end
            end
            if (cmd.publish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/two_sum_pair_query_table_core.sv
// two-sum pair query table
// request channel (req_valid/req_ready) carries opcode, add_value and query_sum;
// opcode add records add_value in a table of up to 64 distinct values, each
// with an occurrence count that saturates at two; opcode find reports whether
// two stored entries (or one entry added at least twice) sum to query_sum
// response channel (rsp_valid/rsp_ready) returns pair_found and add_dropped,
// exactly one response transaction per request transaction
// one request is worked at a time; each table read goes through the
// registered table memory; an add reads entries in turn up to the matching
// one (all used entries when none matches), and a find examines entry pairs
// (i <= j) in turn, at most used*(used+1)/2 of them, until one matches;
// the next request is accepted in the cycle after the response loads
// the result sits in an output register: the next request is accepted while
// a response still waits; if the receiver stalls, a finished request holds
// in its last step until the output register frees up
// reset empties the table and drops any response in flight; no clearing pass
module two_sum_pair_query_table_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic                                 opcode,
    input  logic signed [tspq_pkg::ADD_W-1:0]    add_value,
    input  logic signed [tspq_pkg::QUERY_W-1:0]  query_sum,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic                                 pair_found,
    output logic                                 add_dropped
);
    import tspq_pkg::*;

    tspq_cmd_t    cmd;
    tspq_status_t status;

    tspq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tspq_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (opcode),
        .add_value   (add_value),
        .query_sum   (query_sum),
        .cmd         (cmd),
        .status      (status),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .pair_found  (pair_found),
        .add_dropped (add_dropped)
    );

endmodule
